[rtl/rba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted buffer allocator package
// Operation and status codes, default sizes and the request and response
// payload types shared by the allocator and its free list.
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam int NUM_INDICES_DEF = 256;
  localparam int NUM_BUFFERS_DEF = 64;
  localparam int COUNT_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_INC   = 2'd1,
    FUNC_DEC   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOBUF     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] tile_index;
  } req_t;

  typedef struct packed {
    logic [5:0] buffer_id;
    logic [1:0] status;
    logic [7:0] count_after;
    logic       freed;
  } rsp_t;

  typedef struct packed {
    logic pop;
    logic push;
  } fl_ctrl_t;

endpackage

[rtl/rba_free_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free buffer list
// Ring of released buffer ids with a registered read of the head entry, so
// that the id to be popped next is always waiting in a register.
// ----------------------------------------------------------------------------
module rba_free_list #(
  parameter int NUM_BUFFERS = rba_pkg::NUM_BUFFERS_DEF,
  localparam int BUF_W = $clog2(NUM_BUFFERS)
) (
  input  logic              clk,
  input  logic              rst,
  input  rba_pkg::fl_ctrl_t ctrl,
  input  logic [BUF_W-1:0]  push_id,
  output logic [BUF_W-1:0]  head_id,
  output logic              nonempty
);

  localparam logic [BUF_W-1:0] LAST_POS = BUF_W'(NUM_BUFFERS - 1);
  localparam logic [BUF_W:0]   FULL_CNT = (BUF_W + 1)'(NUM_BUFFERS);

  logic [BUF_W-1:0] mem [NUM_BUFFERS];
  logic [BUF_W-1:0] head;
  logic [BUF_W-1:0] tail;
  logic [BUF_W:0]   count;
  logic [BUF_W-1:0] head_next;
  logic [BUF_W-1:0] tail_next;
  logic [BUF_W:0]   count_next;
  logic             push_ok;
  logic [BUF_W-1:0] head_rd;

  assign push_ok  = ctrl.push && (count != FULL_CNT);
  assign nonempty = (count != '0);
  assign head_id  = head_rd;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (ctrl.pop) begin
      head_next = (head == LAST_POS) ? '0 : head + BUF_W'(1);
    end
    if (push_ok) begin
      tail_next = (tail == LAST_POS) ? '0 : tail + BUF_W'(1);
    end
    if (ctrl.pop && !push_ok) begin
      count_next = count - (BUF_W + 1)'(1);
    end else if (push_ok && !ctrl.pop) begin
      count_next = count + (BUF_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= push_id;
    end
    if (push_ok && (tail == head_next)) begin
      head_rd <= push_id;
    end else begin
      head_rd <= mem[head_next];
    end
  end

endmodule

[rtl/refcounted_buffer_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted buffer allocator
// Maps tile indices to buffer ids, keeps a reference count per index and
// recycles released buffers through a free list.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (req_valid, req_stall, req) and each one
// produces exactly one response on the rsp channel (rsp_valid, rsp_stall,
// rsp), in request order.
// A request is taken into a working register at the transfer, where the map
// and count memories are read. When the output register is free or its
// response is being taken, the result is written to the output register.
// One request is accepted every cycle while the receiver does not stall.
// The registered memory read and the single read-modify-write of each table
// shape this pipeline; a write from the previous request is forwarded when the
// same index follows at once.
// Reset clears the valid bits of the map and the counts, the free list
// pointers and the fresh id counter; the block is ready in the cycle after
// reset is released.
// When the receiver stalls, the response is held and one more request may
// enter the working register; further requests then see req_stall high.
// ----------------------------------------------------------------------------
module refcounted_buffer_allocator #(
  parameter int NUM_INDICES = rba_pkg::NUM_INDICES_DEF,
  parameter int NUM_BUFFERS = rba_pkg::NUM_BUFFERS_DEF,
  parameter int COUNT_BITS  = rba_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rba_pkg::rsp_t rsp
);

  localparam int IDX_W = (NUM_INDICES > 1) ? $clog2(NUM_INDICES) : 1;
  localparam int BUF_W = $clog2(NUM_BUFFERS);
  localparam logic [BUF_W:0] FRESH_END = (BUF_W + 1)'(NUM_BUFFERS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [BUF_W-1:0]      map_mem [NUM_INDICES];
  logic [COUNT_BITS-1:0] cnt_mem [NUM_INDICES];
  logic [NUM_INDICES-1:0] map_vld;
  logic [NUM_INDICES-1:0] cnt_vld;

  logic                  req_fire;
  logic [IDX_W-1:0]      req_idx;
  logic                  s1_valid;
  logic                  s1_fire;
  logic [1:0]            s1_func;
  logic [IDX_W-1:0]      s1_idx;
  logic                  s1_in_range;
  logic [BUF_W-1:0]      map_rd;
  logic [COUNT_BITS-1:0] cnt_rd;

  logic                  fwd_map_vld;
  logic [IDX_W-1:0]      fwd_map_idx;
  logic [BUF_W-1:0]      fwd_map_id;
  logic                  fwd_cnt_vld;
  logic [IDX_W-1:0]      fwd_cnt_idx;
  logic [COUNT_BITS-1:0] fwd_cnt;

  logic [BUF_W:0]        fresh;
  logic                  fl_nonempty;
  logic [BUF_W-1:0]      fl_head_id;
  rba_pkg::fl_ctrl_t     fl_ctrl;

  logic                  mv;
  logic [BUF_W-1:0]      mid;
  logic [BUF_W-1:0]      cur_id;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  cnt_we;
  logic                  map_set;
  logic                  map_clr;
  logic                  do_pop;
  logic                  do_push;
  logic                  fresh_inc;
  logic [BUF_W-1:0]      res_id;
  rba_pkg::status_t      res_st;
  logic [COUNT_BITS-1:0] res_cnt;
  logic                  res_freed;

  assign req_fire  = req_valid && !req_stall;
  assign req_stall = s1_valid && !s1_fire;
  assign s1_fire   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_idx   = IDX_W'(req.tile_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_func     <= req.func;
      s1_idx      <= req_idx;
      s1_in_range <= (32'(req.tile_index) < 32'(NUM_INDICES));
      map_rd      <= map_mem[req_idx];
      cnt_rd      <= cnt_mem[req_idx];
    end
  end

  always_comb begin
    mv     = map_vld[s1_idx];
    mid    = (fwd_map_vld && (fwd_map_idx == s1_idx)) ? fwd_map_id : map_rd;
    cur_id = mv ? mid : '0;
    if (!cnt_vld[s1_idx]) begin
      cnt = '0;
    end else if (fwd_cnt_vld && (fwd_cnt_idx == s1_idx)) begin
      cnt = fwd_cnt;
    end else begin
      cnt = cnt_rd;
    end
  end

  always_comb begin
    res_id    = '0;
    res_st    = rba_pkg::ST_OK;
    res_cnt   = '0;
    res_freed = 1'b0;
    cnt_new   = cnt;
    cnt_we    = 1'b0;
    map_set   = 1'b0;
    map_clr   = 1'b0;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    fresh_inc = 1'b0;
    if (s1_in_range) begin
      unique case (s1_func)
        rba_pkg::FUNC_ALLOC: begin
          res_cnt = cnt;
          priority if (mv) begin
            res_id = mid;
          end else if (fl_nonempty) begin
            res_id  = fl_head_id;
            do_pop  = 1'b1;
            map_set = 1'b1;
          end else if (fresh != FRESH_END) begin
            res_id    = fresh[BUF_W-1:0];
            fresh_inc = 1'b1;
            map_set   = 1'b1;
          end else begin
            res_st = rba_pkg::ST_EXHAUSTED;
          end
        end
        rba_pkg::FUNC_INC: begin
          cnt_new = (cnt == CNT_MAX) ? cnt : cnt + COUNT_BITS'(1);
          cnt_we  = 1'b1;
          res_id  = cur_id;
          res_cnt = cnt_new;
        end
        rba_pkg::FUNC_DEC: begin
          cnt_new = cnt - COUNT_BITS'(1);
          priority if (cnt == '0) begin
            res_id = cur_id;
            res_st = rba_pkg::ST_UNDERFLOW;
          end else if (cnt_new != '0) begin
            cnt_we  = 1'b1;
            res_id  = cur_id;
            res_cnt = cnt_new;
          end else if (!mv) begin
            cnt_we = 1'b1;
            res_st = rba_pkg::ST_NOBUF;
          end else begin
            cnt_we    = 1'b1;
            res_id    = cur_id;
            res_freed = 1'b1;
            do_push   = 1'b1;
            map_clr   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign fl_ctrl.pop  = s1_fire && do_pop;
  assign fl_ctrl.push = s1_fire && do_push;

  rba_free_list #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_free_list (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (fl_ctrl),
    .push_id  (cur_id),
    .head_id  (fl_head_id),
    .nonempty (fl_nonempty)
  );

  always_ff @(posedge clk) begin
    if (s1_fire && map_set) begin
      map_mem[s1_idx] <= res_id;
    end
    if (s1_fire && cnt_we) begin
      cnt_mem[s1_idx] <= cnt_new;
    end
    if (s1_fire && map_set) begin
      fwd_map_idx <= s1_idx;
      fwd_map_id  <= res_id;
    end
    if (s1_fire && cnt_we) begin
      fwd_cnt_idx <= s1_idx;
      fwd_cnt     <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld     <= '0;
      cnt_vld     <= '0;
      fwd_map_vld <= 1'b0;
      fwd_cnt_vld <= 1'b0;
      fresh       <= '0;
    end else begin
      if (s1_fire && map_set) begin
        map_vld[s1_idx] <= 1'b1;
        fwd_map_vld     <= 1'b1;
      end else if (s1_fire && map_clr) begin
        map_vld[s1_idx] <= 1'b0;
      end
      if (s1_fire && cnt_we) begin
        cnt_vld[s1_idx] <= 1'b1;
        fwd_cnt_vld     <= 1'b1;
      end
      if (s1_fire && fresh_inc) begin
        fresh <= fresh + (BUF_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp.buffer_id   <= 6'(res_id);
      rsp.status      <= res_st;
      rsp.count_after <= 8'(res_cnt);
      rsp.freed       <= res_freed;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    fl_ctrl.pop |-> fl_nonempty)
    else $error("A buffer was taken from an empty free list.");

  a_pop_push_excl: assert property (@(posedge clk) disable iff (rst)
    fl_ctrl.pop |-> !fl_ctrl.push)
    else $error("One request both took and released a buffer.");

  a_fire_rsp: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> rsp_valid)
    else $error("A completed request left no response.");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_idx) && $stable(s1_func))
    else $error("A held request changed before its response was written.");

  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    s1_fire && res_freed |-> map_clr && fl_ctrl.push && (cnt_new == '0))
    else $error("A buffer was released without clearing its mapping.");

endmodule

[test/rba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer allocator checker
// Watches the request and response channels of the allocator and keeps its
// own copy of the index map, the reference counts and the free ring. Every
// request transfer yields one predicted response, and every response transfer
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rba_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  rba_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  rba_pkg::rsp_t rsp,
  output int            errors,
  output int            pending
);

  localparam logic [7:0] COUNT_TOP = 8'hFF;

  logic          map_live [rba_pkg::NUM_INDICES_DEF];
  logic [5:0]    map_buf  [rba_pkg::NUM_INDICES_DEF];
  logic [7:0]    ref_cnt  [rba_pkg::NUM_INDICES_DEF];
  logic [5:0]    free_ring [rba_pkg::NUM_BUFFERS_DEF];
  int            ring_rd;
  int            ring_wr;
  int            ring_fill;
  int            next_fresh;
  rba_pkg::rsp_t rsp_due [$];
  rba_pkg::rsp_t want;

  function automatic rba_pkg::rsp_t apply_request(rba_pkg::req_t r);
    rba_pkg::rsp_t res;
    logic [7:0]    cnt;
    logic [5:0]    id;
    int            ix;
    res = '0;
    ix  = r.tile_index;
    cnt = ref_cnt[ix];
    id  = map_live[ix] ? map_buf[ix] : 6'd0;
    case (r.func)
      rba_pkg::FUNC_ALLOC: begin
        res.count_after = cnt;
        res.status      = rba_pkg::ST_OK;
        if (map_live[ix]) begin
          res.buffer_id = map_buf[ix];
        end else if (ring_fill > 0) begin
          res.buffer_id = free_ring[ring_rd];
          ring_rd       = (ring_rd + 1) % rba_pkg::NUM_BUFFERS_DEF;
          ring_fill--;
          map_live[ix]  = 1'b1;
          map_buf[ix]   = res.buffer_id;
        end else if (next_fresh < rba_pkg::NUM_BUFFERS_DEF) begin
          res.buffer_id = 6'(next_fresh);
          next_fresh++;
          map_live[ix]  = 1'b1;
          map_buf[ix]   = res.buffer_id;
        end else begin
          res.status = rba_pkg::ST_EXHAUSTED;
        end
      end
      rba_pkg::FUNC_INC: begin
        if (cnt != COUNT_TOP) cnt++;
        ref_cnt[ix]     = cnt;
        res.buffer_id   = id;
        res.status      = rba_pkg::ST_OK;
        res.count_after = cnt;
      end
      rba_pkg::FUNC_DEC: begin
        res.buffer_id = id;
        if (cnt == 8'd0) begin
          res.status = rba_pkg::ST_UNDERFLOW;
        end else begin
          cnt--;
          ref_cnt[ix]     = cnt;
          res.count_after = cnt;
          res.status      = rba_pkg::ST_OK;
          if (cnt == 8'd0) begin
            if (!map_live[ix]) begin
              res.status = rba_pkg::ST_NOBUF;
            end else begin
              if (ring_fill < rba_pkg::NUM_BUFFERS_DEF) begin
                free_ring[ring_wr] = id;
                ring_wr            = (ring_wr + 1) % rba_pkg::NUM_BUFFERS_DEF;
                ring_fill++;
              end
              map_live[ix] = 1'b0;
              map_buf[ix]  = 6'd0;
              res.freed    = 1'b1;
            end
          end
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rba_pkg::NUM_INDICES_DEF; i++) begin
        map_live[i] = 1'b0;
        map_buf[i]  = 6'd0;
        ref_cnt[i]  = 8'd0;
      end
      ring_rd    = 0;
      ring_wr    = 0;
      ring_fill  = 0;
      next_fresh = 0;
      errors     = 0;
      rsp_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          errors++;
          $display("%0t: response expected none, actual %h", $time, rsp);
        end else begin
          want = rsp_due.pop_front();
          check_field("buffer_id", want.buffer_id, rsp.buffer_id);
          check_field("status", want.status, rsp.status);
          check_field("count_after", want.count_after, rsp.count_after);
          check_field("freed", want.freed, rsp.freed);
        end
      end
      if (req_valid && !req_stall) rsp_due.push_back(apply_request(req));
    end
    pending <= rsp_due.size();
  end

endmodule

[test/tb_refcounted_buffer_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer allocator testbench
// Drives directed and random allocate, increment, decrement and unused-code requests into
// the allocator with random gaps and response stalls, and leaves prediction
// and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module tb_refcounted_buffer_allocator;

  localparam int ITEM_TARGET = 650;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  rba_pkg::req_t req       = '0;
  logic          rsp_stall = 1'b0;
  logic          req_stall;
  logic          rsp_valid;
  rba_pkg::rsp_t rsp;
  int            errors;
  int            pending;
  int            sent_items = 0;
  logic          no_idle    = 1'b0;

  refcounted_buffer_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  rba_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_request(input logic [1:0] f, input logic [7:0] idx);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{func: f, tile_index: idx};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (!rst && !no_idle && $urandom_range(0, 7) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [7:0] base;
    logic [7:0] idx;
    int         n;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(rba_pkg::FUNC_ALLOC, 8'h00);
    send_request(rba_pkg::FUNC_ALLOC, 8'h00);
    send_request(rba_pkg::FUNC_INC, 8'h00);
    send_request(rba_pkg::FUNC_INC, 8'h00);
    send_request(rba_pkg::FUNC_DEC, 8'h00);
    send_request(rba_pkg::FUNC_DEC, 8'h00);
    send_request(rba_pkg::FUNC_DEC, 8'h00);
    send_request(rba_pkg::FUNC_ALLOC, 8'hFF);
    send_request(2'd3, 8'hFF);
    send_request(rba_pkg::FUNC_INC, 8'h80);
    send_request(rba_pkg::FUNC_DEC, 8'h80);
    send_request(rba_pkg::FUNC_DEC, 8'h80);
    send_request(rba_pkg::FUNC_INC, 8'hFF);
    send_request(rba_pkg::FUNC_DEC, 8'hFF);
    send_request(2'd3, 8'h00);
    send_request(2'd3, 8'h55);
    send_request(rba_pkg::FUNC_ALLOC, 8'h55);
    send_request(rba_pkg::FUNC_ALLOC, 8'hAA);
    send_request(rba_pkg::FUNC_INC, 8'hAA);
    send_request(rba_pkg::FUNC_DEC, 8'h55);
    send_request(rba_pkg::FUNC_ALLOC, 8'hFF);

    // Running the pool dry takes more distinct indices than there are buffers.
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < 70; i++) send_request(rba_pkg::FUNC_ALLOC, base + 8'(i));

    idx = 8'($urandom_range(0, 255));
    send_request(rba_pkg::FUNC_ALLOC, idx);
    for (int i = 0; i < 258; i++) send_request(rba_pkg::FUNC_INC, idx);
    for (int i = 0; i < 3; i++) send_request(rba_pkg::FUNC_DEC, idx);

    while (sent_items < ITEM_TARGET) begin
      if (sent_items % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (sent_items > ITEM_TARGET - 80) no_idle = 1'b1;
      idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 65) begin
        n = $urandom_range(1, 3);
        send_request(rba_pkg::FUNC_ALLOC, idx);
        for (int i = 0; i < n; i++) send_request(rba_pkg::FUNC_INC, idx);
        for (int i = 0; i < n; i++) send_request(rba_pkg::FUNC_DEC, idx);
      end else begin
        send_request(2'($urandom_range(0, 3)), idx);
      end
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
